>>> rtl/core/lvs_pkg.sv
// Shared types and fixed widths for the Legendre value and slope block.
`default_nettype none

package lvs_pkg;

    localparam int DEG_W   = 5;
    localparam int NUM_DEG = 2 ** DEG_W;
    localparam int VAL_W   = 32;
    localparam int SLP_W   = 48;
    localparam int SUM_W   = 64;
    localparam int DIGIT_W = SLP_W / 2;

    // multiplier A operand
    typedef enum logic [1:0] {
        OPA_COEF_A,
        OPA_COEF_B,
        OPA_AX
    } t_opa_sel;

    // multiplier B operand
    typedef enum logic [2:0] {
        OPB_X,
        OPB_P1,
        OPB_P2,
        OPB_S1,
        OPB_S2
    } t_opb_sel;

    // where a finished product lands
    typedef enum logic [1:0] {
        DST_AX,
        DST_V,
        DST_D
    } t_dest;

    // source of a committed result
    typedef enum logic [1:0] {
        SRC_SEED0,
        SRC_SEED1,
        SRC_SUM
    } t_src;

    typedef struct packed {
        logic             load_x;
        logic             clear_sums;
        logic             issue;
        logic             digit;
        t_opa_sel         sel_a;
        t_opb_sel         sel_b;
        t_dest            dest;
        logic             negate;
        logic             commit;
        t_src             src;
        logic             last;
        logic [DEG_W-1:0] degree;
    } t_lvs_cmd;

endpackage

`default_nettype wire

>>> rtl/core/lvs_datapath.sv
// Datapath: coefficient table, shared digit multiplier, rounding, sums and history.
`default_nettype none

module lvs_datapath import lvs_pkg::*; #(
    parameter int FRACTION_BITS = 30
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire t_lvs_cmd           i_cmd,
    input  wire signed [VAL_W-1:0]  i_abscissa,
    output logic                    o_busy,
    output logic [DEG_W-1:0]        o_degree_index,
    output logic signed [VAL_W-1:0] o_poly_value,
    output logic signed [SLP_W-1:0] o_poly_slope,
    output logic                    o_last_of_run
);

    localparam int CW    = FRACTION_BITS + 1;
    localparam int AW    = (CW > 33) ? CW : 33;
    localparam int PW    = AW + DIGIT_W;
    localparam int ACC_W = AW + SLP_W;
    localparam int RW    = ACC_W + 1;
    localparam int MAG_W = SUM_W - 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [SLP_W-1:0] SLP_MAX = {1'b0, {(SLP_W-1){1'b1}}};
    localparam logic signed [SLP_W-1:0] SLP_MIN = {1'b1, {(SLP_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] ONE_V   = (FRACTION_BITS >= VAL_W - 1) ? VAL_MAX :
                                                  (VAL_W'(1) << FRACTION_BITS);
    localparam logic signed [SLP_W-1:0] ONE_D   = (FRACTION_BITS >= SLP_W - 1) ? SLP_MAX :
                                                  (SLP_W'(1) << FRACTION_BITS);

    // (2l-1)/l and (l-1)/l, rounded to nearest
    logic [CW-1:0] coef_a_tab [NUM_DEG];
    logic [CW-1:0] coef_b_tab [NUM_DEG];

    for (genvar g = 0; g < NUM_DEG; g++) begin : g_coef
        if (g < 2) begin : g_seed
            assign coef_a_tab[g] = '0;
            assign coef_b_tab[g] = '0;
        end else begin : g_ratio
            localparam logic [63:0] A_NUM = (64'(2 * g - 1) << FRACTION_BITS) + 64'(g / 2);
            localparam logic [63:0] B_NUM = (64'(g - 1) << FRACTION_BITS) + 64'(g / 2);
            localparam logic [63:0] A_VAL = A_NUM / 64'(g);
            localparam logic [63:0] B_VAL = B_NUM / 64'(g);
            assign coef_a_tab[g] = A_VAL[CW-1:0];
            assign coef_b_tab[g] = B_VAL[CW-1:0];
        end
    end

    logic signed [VAL_W-1:0] r_x;
    logic signed [VAL_W-1:0] r_p1, r_p2;
    logic signed [SLP_W-1:0] r_s1, r_s2;
    logic [AW-1:0]           r_ax_mag;
    logic                    r_ax_neg;
    logic signed [SUM_W-1:0] r_sum_v, r_sum_d;

    // operand stage
    logic                    r_op_valid;
    logic [AW-1:0]           r_opa_mag;
    logic [SLP_W-1:0]        r_opb_mag;
    logic                    r_op_neg, r_op_digit;
    t_dest                   r_op_dest;
    // product stage
    logic                    r_pr_valid;
    logic [PW-1:0]           r_prod;
    logic                    r_pr_neg, r_pr_digit;
    t_dest                   r_pr_dest;
    // partial-sum stage
    logic                    r_acc_valid;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_acc_neg;
    t_dest                   r_acc_dest;
    // rounded term stage
    logic                    r_tm_valid;
    logic [MAG_W-1:0]        r_tm_mag;
    logic                    r_tm_neg;
    t_dest                   r_tm_dest;

    logic [AW-1:0]           opa_mag;
    logic                    opa_neg;
    logic signed [SLP_W-1:0] opb_val;
    logic [SLP_W-1:0]        opb_mag;
    logic [DIGIT_W-1:0]      mul_digit;
    logic [RW-1:0]           rnd_sum, rnd_shift;
    logic                    rnd_ovf;
    logic [MAG_W-1:0]        rnd_mag;
    logic signed [SUM_W-1:0] add_src;
    logic [SUM_W:0]          add_ext, mag_ext, add_res;
    logic signed [SUM_W-1:0] add_sat;
    logic signed [VAL_W-1:0] new_v;
    logic signed [SLP_W-1:0] new_d;

    always_comb begin
        case (i_cmd.sel_a)
            OPA_COEF_A: begin
                opa_mag = AW'(coef_a_tab[i_cmd.degree]);
                opa_neg = 1'b0;
            end
            OPA_COEF_B: begin
                opa_mag = AW'(coef_b_tab[i_cmd.degree]);
                opa_neg = 1'b0;
            end
            OPA_AX: begin
                opa_mag = r_ax_mag;
                opa_neg = r_ax_neg;
            end
            default: begin
                opa_mag = '0;
                opa_neg = 1'b0;
            end
        endcase
        case (i_cmd.sel_b)
            OPB_X:   opb_val = SLP_W'(r_x);
            OPB_P1:  opb_val = SLP_W'(r_p1);
            OPB_P2:  opb_val = SLP_W'(r_p2);
            OPB_S1:  opb_val = r_s1;
            OPB_S2:  opb_val = r_s2;
            default: opb_val = '0;
        endcase
        opb_mag = opb_val[SLP_W-1] ? (~opb_val + SLP_W'(1)) : opb_val;
    end

    assign mul_digit = r_op_digit ? r_opb_mag[SLP_W-1:DIGIT_W] : r_opb_mag[DIGIT_W-1:0];

    // round half away from zero on the magnitude, clamp to the 64-bit range
    always_comb begin
        rnd_sum   = RW'(r_acc) + (RW'(1) << (FRACTION_BITS - 1));
        rnd_shift = rnd_sum >> FRACTION_BITS;
        rnd_ovf   = |rnd_shift[RW-1:MAG_W];
        rnd_mag   = rnd_ovf ? '1 : rnd_shift[MAG_W-1:0];
    end

    // saturating accumulate into the value or slope sum
    always_comb begin
        add_src = (r_tm_dest == DST_V) ? r_sum_v : r_sum_d;
        add_ext = {add_src[SUM_W-1], add_src};
        mag_ext = {2'b00, r_tm_mag};
        add_res = r_tm_neg ? (add_ext - mag_ext) : (add_ext + mag_ext);
        if (add_res[SUM_W] != add_res[SUM_W-1]) begin
            add_sat = add_res[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            add_sat = add_res[SUM_W-1:0];
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_SEED0: begin
                new_v = ONE_V;
                new_d = '0;
            end
            SRC_SEED1: begin
                new_v = r_x;
                new_d = ONE_D;
            end
            SRC_SUM: begin
                if ((&r_sum_v[SUM_W-1:VAL_W-1]) || !(|r_sum_v[SUM_W-1:VAL_W-1])) begin
                    new_v = r_sum_v[VAL_W-1:0];
                end else begin
                    new_v = r_sum_v[SUM_W-1] ? VAL_MIN : VAL_MAX;
                end
                if ((&r_sum_d[SUM_W-1:SLP_W-1]) || !(|r_sum_d[SUM_W-1:SLP_W-1])) begin
                    new_d = r_sum_d[SLP_W-1:0];
                end else begin
                    new_d = r_sum_d[SUM_W-1] ? SLP_MIN : SLP_MAX;
                end
            end
            default: begin
                new_v = '0;
                new_d = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid  <= 1'b0;
            r_pr_valid  <= 1'b0;
            r_acc_valid <= 1'b0;
            r_tm_valid  <= 1'b0;
        end else begin
            r_op_valid  <= i_cmd.issue;
            r_pr_valid  <= r_op_valid;
            r_acc_valid <= r_pr_valid && r_pr_digit;
            r_tm_valid  <= r_acc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa_mag  <= opa_mag;
        r_opb_mag  <= opb_mag;
        r_op_neg   <= opa_neg ^ opb_val[SLP_W-1] ^ i_cmd.negate;
        r_op_digit <= i_cmd.digit;
        r_op_dest  <= i_cmd.dest;

        r_prod     <= r_opa_mag * mul_digit;
        r_pr_neg   <= r_op_neg;
        r_pr_digit <= r_op_digit;
        r_pr_dest  <= r_op_dest;

        r_acc      <= r_pr_digit ? (r_acc + (ACC_W'(r_prod) << DIGIT_W)) : ACC_W'(r_prod);
        r_acc_neg  <= r_pr_neg;
        r_acc_dest <= r_pr_dest;

        r_tm_mag   <= rnd_mag;
        r_tm_neg   <= r_acc_neg;
        r_tm_dest  <= r_acc_dest;

        if (i_cmd.load_x) begin
            r_x <= i_abscissa;
        end

        if (r_tm_valid) begin
            case (r_tm_dest)
                DST_AX: begin
                    r_ax_mag <= r_tm_mag[AW-1:0];
                    r_ax_neg <= r_tm_neg;
                end
                DST_V:   r_sum_v <= add_sat;
                DST_D:   r_sum_d <= add_sat;
                default: r_sum_d <= r_sum_d;
            endcase
        end else if (i_cmd.clear_sums) begin
            r_sum_v <= '0;
            r_sum_d <= '0;
        end

        if (i_cmd.commit) begin
            r_p2           <= r_p1;
            r_p1           <= new_v;
            r_s2           <= r_s1;
            r_s1           <= new_d;
            o_poly_value   <= new_v;
            o_poly_slope   <= new_d;
            o_degree_index <= i_cmd.degree;
            o_last_of_run  <= i_cmd.last;
        end
    end

    assign o_busy = r_op_valid || r_pr_valid || r_acc_valid || r_tm_valid;

`ifndef SYNTHESIS
    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !o_busy)
        else $error("result committed while products still in flight");

    a_digit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pr_valid && r_pr_digit) |-> $past(r_pr_valid && !r_pr_digit))
        else $error("upper digit product without its lower digit");

    a_ax_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tm_valid && r_tm_dest == DST_AX) |-> (r_tm_mag[MAG_W-1:AW] == '0))
        else $error("a*x term exceeds its holding register");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lvs_ctrl.sv
// Controller: degree sequencing, multiply schedule and output register handshake.
`default_nettype none

module lvs_ctrl import lvs_pkg::*; #(
    parameter int DEGREE_LIMIT = 31
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire [DEG_W-1:0] i_max_degree,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    input  wire             i_busy,
    output t_lvs_cmd        o_cmd
);

    localparam int DEG_CAP_I = (DEGREE_LIMIT < NUM_DEG - 1) ? DEGREE_LIMIT : NUM_DEG - 1;
    localparam logic [DEG_W-1:0] DEG_CAP = DEG_W'(DEG_CAP_I);
    localparam int OPS = 6;
    localparam logic [3:0] ISSUE_CYCLES = 4'(2 * OPS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EMIT = 3'b010,
        ST_CALC = 3'b100
    } t_state;

    // multiply steps of one degree, in issue order
    typedef enum logic [2:0] {
        OP_AX_FORM,
        OP_D_COEF,
        OP_V_PREV2,
        OP_V_AX,
        OP_D_AX,
        OP_D_PREV2
    } t_op;

    t_state           r_state, n_state;
    logic [DEG_W-1:0] r_deg, n_deg;
    logic [DEG_W-1:0] r_top, n_top;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    t_lvs_cmd         cmd;

    always_comb begin
        n_state    = r_state;
        n_deg      = r_deg;
        n_top      = r_top;
        n_cnt      = r_cnt;
        cmd        = '0;
        cmd.sel_a  = OPA_COEF_A;
        cmd.sel_b  = OPB_X;
        cmd.dest   = DST_AX;
        cmd.src    = SRC_SUM;
        cmd.degree = r_deg;
        cmd.last   = (r_deg == r_top);
        out_free   = !r_out_valid || !i_out_stall;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_x = 1'b1;
                    n_deg      = '0;
                    n_top      = (i_max_degree > DEG_CAP) ? DEG_CAP : i_max_degree;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_deg == '0) begin
                    cmd.src = SRC_SEED0;
                end else if (r_deg == DEG_W'(1)) begin
                    cmd.src = SRC_SEED1;
                end
                if (out_free) begin
                    cmd.commit = 1'b1;
                    if (cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_deg = r_deg + DEG_W'(1);
                        if (r_deg != '0) begin
                            n_state = ST_CALC;
                            n_cnt   = '0;
                        end
                    end
                end
            end
            ST_CALC: begin
                if (r_cnt != ISSUE_CYCLES) begin
                    cmd.issue      = 1'b1;
                    cmd.digit      = r_cnt[0];
                    cmd.clear_sums = (r_cnt == '0);
                    n_cnt          = r_cnt + 4'd1;
                    case (t_op'(r_cnt[3:1]))
                        OP_AX_FORM: begin
                            cmd.sel_a = OPA_COEF_A;
                            cmd.sel_b = OPB_X;
                            cmd.dest  = DST_AX;
                        end
                        OP_D_COEF: begin
                            cmd.sel_a = OPA_COEF_A;
                            cmd.sel_b = OPB_P1;
                            cmd.dest  = DST_D;
                        end
                        OP_V_PREV2: begin
                            cmd.sel_a  = OPA_COEF_B;
                            cmd.sel_b  = OPB_P2;
                            cmd.dest   = DST_V;
                            cmd.negate = 1'b1;
                        end
                        OP_V_AX: begin
                            cmd.sel_a = OPA_AX;
                            cmd.sel_b = OPB_P1;
                            cmd.dest  = DST_V;
                        end
                        OP_D_AX: begin
                            cmd.sel_a = OPA_AX;
                            cmd.sel_b = OPB_S1;
                            cmd.dest  = DST_D;
                        end
                        OP_D_PREV2: begin
                            cmd.sel_a  = OPA_COEF_B;
                            cmd.sel_b  = OPB_S2;
                            cmd.dest   = DST_D;
                            cmd.negate = 1'b1;
                        end
                        default: cmd.issue = 1'b0;
                    endcase
                end else if (!i_busy) begin
                    n_state = ST_EMIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid = cmd.commit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_deg       <= '0;
            r_top       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_deg       <= n_deg;
            r_top       <= n_top;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result committed over an untaken output");

    a_calc_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_deg >= DEG_W'(2) && r_deg <= r_top))
        else $error("recurrence running on a seed or out-of-range degree");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && o_cmd.last) |=> (r_state == ST_IDLE && o_out_valid))
        else $error("run did not close after its final degree");
`endif

endmodule

`default_nettype wire

>>> rtl/core/legendre_value_and_slope_top.sv
// Top level: Legendre P_l(x) and P'_l(x) by the Bonnet recurrence, degrees 0..max_degree.
// The first result (degree 0) is committed from the emit state entered on the input transfer.
// A new abscissa is taken only once the previous run has committed its last degree;
//   each degree from 2 on issues six fixed-point products, each two passes of one
//   shared 24-bit-digit multiplier, then waits for the four-stage product pipeline to drain.
// Reset: synchronous, active low; clears control state, max_degree returns to 4.
`default_nettype none

module legendre_value_and_slope_top import lvs_pkg::*; #(
    parameter int DEGREE_LIMIT  = 31,
    parameter int FRACTION_BITS = 30
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // abscissa input channel
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire signed [VAL_W-1:0]  i_abscissa,
    // result channel
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic [DEG_W-1:0]        o_degree_index,
    output logic signed [VAL_W-1:0] o_poly_value,
    output logic signed [SLP_W-1:0] o_poly_slope,
    output logic                    o_last_of_run,
    // configuration write channel (max_degree)
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [DEG_W-1:0]         i_cfg_data
);

    localparam logic [DEG_W-1:0] MAX_DEGREE_RST = DEG_W'(4);

    logic [DEG_W-1:0] r_max_degree;
    t_lvs_cmd         cmd;
    logic             busy;

    // The user makes register writes only between runs (unenforced); all are taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_degree <= MAX_DEGREE_RST;
        end else if (i_cfg_valid) begin
            r_max_degree <= i_cfg_data;
        end
    end

    // Controller: walks the degrees, schedules the multiply passes and owns
    // the output valid; the output payload sits in the datapath, so a new
    // abscissa can be taken while the final result still waits downstream.
    lvs_ctrl #(
        .DEGREE_LIMIT (DEGREE_LIMIT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_degree (r_max_degree),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_busy       (busy),
        .o_cmd        (cmd)
    );

    // Datapath: ratio table, digit multiplier, rounding, saturating sums,
    // recurrence history and the output register.
    lvs_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_abscissa     (i_abscissa),
        .o_busy         (busy),
        .o_degree_index (o_degree_index),
        .o_poly_value   (o_poly_value),
        .o_poly_slope   (o_poly_slope),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> tb/legendre_term_checker.sv
// Checker: predicts Legendre values and slopes per abscissa and compares each result transfer.
`timescale 1ns / 1ps

module legendre_term_checker import lvs_pkg::*; #(
    parameter int DEGREE_LIMIT  = 31,
    parameter int FRACTION_BITS = 30
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_in_stall,
    input  wire signed [VAL_W-1:0]  i_abscissa,
    input  wire                     i_out_valid,
    input  wire                     i_out_stall,
    input  wire [DEG_W-1:0]         i_degree_index,
    input  wire signed [VAL_W-1:0]  i_poly_value,
    input  wire signed [SLP_W-1:0]  i_poly_slope,
    input  wire                     i_last_of_run,
    input  wire                     i_cfg_valid,
    input  wire                     i_cfg_ready,
    input  wire [DEG_W-1:0]         i_cfg_data,
    output int                      o_mismatches,
    output int                      o_pending,
    output int                      o_runs_done,
    output int                      o_terms_checked
);

    localparam longint POS_LIMIT = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint NEG_LIMIT = 64'sh8000_0000_0000_0000;
    localparam longint UNIT      = longint'(1) <<< FRACTION_BITS;

    typedef struct packed {
        logic [DEG_W-1:0]        degree;
        logic signed [VAL_W-1:0] value;
        logic signed [SLP_W-1:0] slope;
        logic                    last;
    } t_legendre_term;

    t_legendre_term   expected_terms [$];
    t_legendre_term   want;
    logic [DEG_W-1:0] max_degree_copy = 5'd4;
    longint           held_x;
    longint           val_last;
    longint           val_before;
    longint           slope_last;
    longint           slope_before;
    int               degree_done;
    int               mismatches;
    int               runs_done;
    int               terms_checked;

    // round(a*b / 2^F), ties away from zero, magnitude capped at POS_LIMIT
    function automatic longint fx_product(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [63:0]  mag;
        ma   = (a < 0) ? 64'(-a) : 64'(a);
        mb   = (b < 0) ? 64'(-b) : 64'(b);
        prod = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        mag  = (prod[127:63] != '0) ? 64'(POS_LIMIT) : prod[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint sum_sat(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? NEG_LIMIT : POS_LIMIT;
        return longint'(s[63:0]);
    endfunction

    function automatic longint clamp_to(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // (num/l) as unsigned fixed point, rounded to nearest
    function automatic longint bonnet_ratio(int num, int l);
        return ((longint'(num) <<< FRACTION_BITS) + l / 2) / l;
    endfunction

    task automatic predict_terms(input logic signed [VAL_W-1:0] x_in);
        longint         x;
        longint         a;
        longint         b;
        longint         ax;
        longint         v;
        longint         d;
        int             top;
        int             l;
        t_legendre_term term;
        x   = x_in;
        top = max_degree_copy;
        if (top > DEGREE_LIMIT) top = DEGREE_LIMIT;
        if (top > NUM_DEG - 1) top = NUM_DEG - 1;
        held_x = x;
        for (l = 0; l <= top; l++) begin
            if (l == 0) begin
                v = clamp_to(UNIT, VAL_W);
                d = 0;
            end else if (l == 1) begin
                v = x;
                d = clamp_to(UNIT, SLP_W);
            end else begin
                a  = bonnet_ratio(2 * l - 1, l);
                b  = bonnet_ratio(l - 1, l);
                ax = fx_product(a, x);
                v  = sum_sat(fx_product(ax, val_last), -fx_product(b, val_before));
                d  = sum_sat(fx_product(a, val_last), fx_product(ax, slope_last));
                d  = sum_sat(d, -fx_product(b, slope_before));
                v  = clamp_to(v, VAL_W);
                d  = clamp_to(d, SLP_W);
            end
            val_before   = val_last;
            val_last     = v;
            slope_before = slope_last;
            slope_last   = d;
            degree_done  = l;
            term.degree  = DEG_W'(l);
            term.value   = VAL_W'(v);
            term.slope   = SLP_W'(d);
            term.last    = (l == top);
            expected_terms.insert(expected_terms.size(), term);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_degree_copy = 5'd4;
            held_x          = 0;
            val_last        = 0;
            val_before      = 0;
            slope_last      = 0;
            slope_before    = 0;
            degree_done     = 0;
            expected_terms.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                max_degree_copy = i_cfg_data;
            // results first, so a same-edge input cannot feed its own check
            if (i_out_valid && !i_out_stall) begin
                terms_checked++;
                if (i_last_of_run)
                    runs_done++;
                if (expected_terms.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: degree %0d value %h slope %h last %b",
                                 i_degree_index, i_poly_value, i_poly_slope, i_last_of_run);
                end else begin
                    want = expected_terms.pop_front();
                    if (want.degree !== i_degree_index || want.value !== i_poly_value ||
                        want.slope !== i_poly_slope || want.last !== i_last_of_run) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected degree %0d value %h slope %h last %b,",
                                      " got degree %0d value %h slope %h last %b"},
                                     want.degree, want.value, want.slope, want.last,
                                     i_degree_index, i_poly_value, i_poly_slope,
                                     i_last_of_run);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_terms(i_abscissa);
        end
        o_mismatches    <= mismatches;
        o_pending       <= expected_terms.size();
        o_runs_done     <= runs_done;
        o_terms_checked <= terms_checked;
    end

endmodule

>>> tb/tb_legendre_value_and_slope_top.sv
// Testbench top: drives abscissae and max_degree settings into the block and gives the verdict.
`timescale 1ns / 1ps

module tb_legendre_value_and_slope_top import lvs_pkg::*; ();

    localparam int DEGREE_LIMIT   = 31;
    localparam int FRACTION_BITS  = 30;
    // longest legal quiet spell is one degree of recurrence plus a stall; this is far beyond it
    localparam int WATCHDOG_LIMIT = 2000;
    // settling time after the final result, before the verdict
    localparam int TAIL_CYCLES    = 24;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 30;
    // 1.0 in Q2.30
    localparam logic signed [VAL_W-1:0] UNIT = 32'sh4000_0000;

    // corner points for the opening run at the reset degree
    localparam logic signed [VAL_W-1:0] CORNER_POINTS [11] = '{
        32'sh4000_0000,     // +1.0
        32'shC000_0000,     // -1.0
        32'sh0000_0000,     // zero
        32'sh2000_0000,     // +0.5
        32'shE000_0000,     // -0.5
        32'sh7FFF_FFFF,     // most positive, well outside -1..1
        32'sh8000_0000,     // most negative
        32'sh0000_0001,     // smallest step above zero
        32'shFFFF_FFFF,     // smallest step below zero
        32'sh4000_0001,     // just above +1.0
        32'shBFFF_FFFF      // just below -1.0
    };

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic signed [VAL_W-1:0] i_abscissa  = '0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [DEG_W-1:0]        i_cfg_data  = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [DEG_W-1:0]        o_degree_index;
    logic signed [VAL_W-1:0] o_poly_value;
    logic signed [SLP_W-1:0] o_poly_slope;
    logic                    o_last_of_run;
    logic                    o_cfg_ready;

    int mismatches;
    int pending_terms;
    int runs_done;
    int terms_checked;
    int items_sent;
    int degree_writes;
    int quiet_cycles;
    // when set, neither side idles or stalls
    bit steady_pace;

    legendre_value_and_slope_top #(
        .DEGREE_LIMIT  (DEGREE_LIMIT),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_abscissa     (i_abscissa),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_degree_index (o_degree_index),
        .o_poly_value   (o_poly_value),
        .o_poly_slope   (o_poly_slope),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Checker sits beside the block, watching all three channels.
    legendre_term_checker #(
        .DEGREE_LIMIT  (DEGREE_LIMIT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_abscissa      (i_abscissa),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_degree_index  (o_degree_index),
        .i_poly_value    (o_poly_value),
        .i_poly_slope    (o_poly_slope),
        .i_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending_terms),
        .o_runs_done     (runs_done),
        .o_terms_checked (terms_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle or stall length drawn per transfer, zero during steady stretches.
    function automatic int pace();
        return steady_pace ? 0 : $urandom_range(0, 5);
    endfunction

    // Mostly points inside -1..1, some anywhere in the 32-bit range, some exact corners.
    function automatic logic signed [VAL_W-1:0] draw_abscissa();
        int                      pick;
        logic signed [VAL_W-1:0] x;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            x = $urandom_range(0, 32'h8000_0000) - UNIT;
        else if (pick < 90)
            x = $urandom;
        else
            x = CORNER_POINTS[$urandom_range(0, 10)];
        return x;
    endfunction

    // Result side: after each transfer, hold stall for a drawn number of cycles.
    // The count runs whether or not a result is waiting, so stalls land on every
    // phase of the block's recurrence.
    always @(posedge i_clk) begin : result_sink
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            n = 0;
        end else if (o_out_valid && !i_out_stall) begin
            n = pace();
            i_out_stall <= (n != 0);
        end else if (n > 1) begin
            n = n - 1;
        end else begin
            n = 0;
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: any stretch without a single transfer on any channel is a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One abscissa transfer. Valid stays high straight into the next item when
    // the drawn gap is zero, so it is never dropped and raised in one step.
    task automatic send_abscissa(input logic signed [VAL_W-1:0] x);
        int gap;
        gap = pace();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_abscissa <= x;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Stop sending and wait until every run sent so far has ended with its last term.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (runs_done < items_sent)
            @(posedge i_clk);
    endtask

    // max_degree is only changed with the block drained.
    task automatic write_max_degree(input logic [DEG_W-1:0] deg);
        settle_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= deg;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        degree_writes++;
    endtask

    initial begin : stimulus
        int phase;
        int k;
        logic [DEG_W-1:0] deg;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners at the reset degree of 4, then the degree extremes
        // (31 for the longest recurrence, 0 for the single-term run) and the
        // smallest settings, 1 and 2, the latter where the recurrence first starts.
        foreach (CORNER_POINTS[i])
            send_abscissa(CORNER_POINTS[i]);

        write_max_degree(5'd31);
        send_abscissa(UNIT);
        send_abscissa(-UNIT);
        send_abscissa(32'sh7FFF_FFFF);
        send_abscissa(32'sh8000_0000);
        send_abscissa(32'sh2CCC_CCCD);

        write_max_degree(5'd0);
        send_abscissa(32'sh0000_0000);
        send_abscissa(32'sh7FFF_FFFF);
        send_abscissa(32'sh8000_0000);

        write_max_degree(5'd1);
        send_abscissa(32'sh2000_0000);
        send_abscissa(32'sh8000_0000);

        write_max_degree(5'd2);
        send_abscissa(32'shE000_0000);
        send_abscissa(32'sh7FFF_FFFF);

        // Random phases, each at its own degree; the first three pin the extremes
        // and the smallest nonzero setting. Every fourth phase runs without idling.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       deg = 5'd0;
                1:       deg = 5'd31;
                2:       deg = 5'd1;
                default: deg = DEG_W'($urandom_range(0, 31));
            endcase
            write_max_degree(deg);
            steady_pace = (phase % 4 == 2);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // once mid-phase, hold the sender until the block has drained
                if (phase == 5 && k == PHASE_ITEMS / 2)
                    settle_idle();
                send_abscissa(draw_abscissa());
            end
        end
        steady_pace = 1'b0;

        // Drain, then leave room for any stray result before the verdict.
        settle_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d abscissae across %0d max_degree writes (0 to 31);",
                 items_sent, degree_writes);
        $display("compared %0d result terms, %0d mismatched, %0d never arrived.",
                 terms_checked, mismatches, pending_terms);
        if (mismatches == 0 && pending_terms == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
